>>> hdl/radix_converter_top_defines.svh
// assertion macros for the radix converter top level
// expects clk and arst_n in the scope where a macro is used
`ifndef RADIX_CONVERTER_TOP_DEFINES_SVH
`define RADIX_CONVERTER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RADCONV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define RADCONV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/radconv_pkg.sv
// shared types and constants of the radix converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package radconv_pkg;

	// configuration register indexes
	localparam int CFG_INDEX_BITS = 1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IN_BASE  = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_OUT_BASE = 1'b1;

	localparam int BASE_BITS = 6;
	localparam logic [BASE_BITS-1:0] IN_BASE_RESET  = 6'd10;
	localparam logic [BASE_BITS-1:0] OUT_BASE_RESET = 6'd2;
	localparam logic [BASE_BITS-1:0] MIN_BASE       = 6'd2;

	// character codes
	localparam logic [7:0] CHAR_MINUS    = 8'h2D;
	localparam logic [7:0] CHAR_ZERO     = 8'h30;
	localparam logic [7:0] CHAR_NINE     = 8'h39;
	localparam logic [7:0] LETTER_OFFSET = 8'd55;

	// digit store
	localparam int STORE_DEPTH = 32;
	localparam int STORE_ADDR_BITS = 5;
	localparam int COUNT_BITS = 6;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture a character
		logic acc_upd;   // fold it into the accumulator, prime the divider
		logic div_step;  // one quotient bit
		logic wr_digit;  // store remainder, restart divider
		logic rd_digit;  // read one stored digit
		logic emit;      // digit on the result ports
	} radconv_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_last;   // final quotient bit this cycle
		logic quot_zero;  // quotient is zero
		logic rd_zero;    // read pointer at the least significant digit
	} radconv_status_t;

endpackage

`default_nettype wire

>>> hdl/radconv_ctrl.sv
// controller state machine of the radix converter
// depends on radconv_pkg
`timescale 1ns / 1ps
`default_nettype none

module radconv_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic                         last_char,
	input  wire radconv_pkg::radconv_status_t status,
	output radconv_pkg::radconv_cmd_t         cmd,
	output logic                              busy,
	output logic                              digit_strobe
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ACC  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_WR   = 3'd3;
	localparam logic [2:0] ST_RD   = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       last_q;
	logic       accept;

	assign accept = start && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_q <= last_char;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc_upd = 1'b1;
				state_d = last_q ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_WR;
				end
			end
			ST_WR: begin
				cmd.wr_digit = 1'b1;
				state_d = status.quot_zero ? ST_RD : ST_DIV;
			end
			ST_RD: begin
				cmd.rd_digit = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				cmd.emit = 1'b1;
				state_d = status.rd_zero ? ST_IDLE : ST_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign digit_strobe = (state_q == ST_OUT);

endmodule

`default_nettype wire

>>> hdl/radconv_dpath.sv
// datapath of the radix converter: accumulator, bit-serial divider, digit store
// depends on radconv_pkg
`timescale 1ns / 1ps
`default_nettype none

module radconv_dpath #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [radconv_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [radconv_pkg::BASE_BITS-1:0]      cfg_data,
	input  wire logic [7:0]                             char_code,
	input  wire radconv_pkg::radconv_cmd_t              cmd,
	output radconv_pkg::radconv_status_t                status,
	output logic [5:0]                                  digit_value,
	output logic                                        is_negative,
	output logic                                        last_digit
);

	localparam int BIT_CNT_W = $clog2(VALUE_BITS);
	localparam logic [BIT_CNT_W-1:0] BIT_CNT_TOP = BIT_CNT_W'(VALUE_BITS - 1);

	logic [radconv_pkg::BASE_BITS-1:0] in_base_q;
	logic [radconv_pkg::BASE_BITS-1:0] out_base_q;
	logic [radconv_pkg::BASE_BITS-1:0] div_base;

	logic [VALUE_BITS-1:0] acc_q;
	logic                  neg_q;
	logic                  first_q;

	logic [VALUE_BITS+5:0] prod_full;
	logic [VALUE_BITS-1:0] char_digit;
	logic                  is_dec;
	logic [VALUE_BITS-1:0] prod_s1;
	logic [VALUE_BITS-1:0] digit_s1;
	logic                  skip_s1;
	logic [VALUE_BITS-1:0] acc_next;

	logic [VALUE_BITS-1:0]                    v_q;
	logic [5:0]                               rem_q;
	logic [BIT_CNT_W-1:0]                     bit_cnt_q;
	logic [6:0]                               trial;
	logic                                     q_bit;
	logic [5:0]                               rem_next;
	logic [radconv_pkg::COUNT_BITS-1:0]       cnt_q;
	logic [radconv_pkg::STORE_ADDR_BITS-1:0]  rd_ptr_q;
	logic [5:0]                               rd_data_q;
	logic [5:0] store_mem [radconv_pkg::STORE_DEPTH];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_base_q  <= radconv_pkg::IN_BASE_RESET;
			out_base_q <= radconv_pkg::OUT_BASE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				radconv_pkg::REG_IN_BASE:  in_base_q  <= cfg_data;
				radconv_pkg::REG_OUT_BASE: out_base_q <= cfg_data;
			endcase
		end
	end

	assign div_base = (out_base_q < radconv_pkg::MIN_BASE) ? radconv_pkg::MIN_BASE : out_base_q;

	// character decode, wraps as an unsigned magnitude
	assign is_dec = (char_code >= radconv_pkg::CHAR_ZERO) && (char_code <= radconv_pkg::CHAR_NINE);
	assign char_digit = is_dec ? VALUE_BITS'(char_code - radconv_pkg::CHAR_ZERO)
		: VALUE_BITS'(char_code) - VALUE_BITS'(radconv_pkg::LETTER_OFFSET);
	assign prod_full = acc_q * in_base_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			prod_s1  <= prod_full[VALUE_BITS-1:0];
			digit_s1 <= char_digit;
			skip_s1  <= first_q && (char_code == radconv_pkg::CHAR_MINUS);
		end
	end

	assign acc_next = skip_s1 ? acc_q : prod_s1 + digit_s1;

	// restoring divider, one quotient bit per cycle
	assign trial    = {rem_q, v_q[VALUE_BITS-1]};
	assign q_bit    = (trial >= {1'b0, div_base});
	assign rem_next = q_bit ? 6'(trial - {1'b0, div_base}) : trial[5:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			neg_q     <= 1'b0;
			first_q   <= 1'b1;
			bit_cnt_q <= '0;
			cnt_q     <= '0;
		end else begin
			if (cmd.acc_upd) begin
				acc_q     <= acc_next;
				neg_q     <= neg_q | skip_s1;
				first_q   <= 1'b0;
				bit_cnt_q <= BIT_CNT_TOP;
				cnt_q     <= '0;
			end
			if (cmd.div_step) begin
				bit_cnt_q <= bit_cnt_q - 1'b1;
			end
			if (cmd.wr_digit) begin
				bit_cnt_q <= BIT_CNT_TOP;
				if (!cnt_q[radconv_pkg::COUNT_BITS-1]) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			// numeral done after the least significant digit
			if (cmd.emit && status.rd_zero) begin
				acc_q   <= '0;
				neg_q   <= 1'b0;
				first_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_upd) begin
			v_q   <= acc_next;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			v_q   <= {v_q[VALUE_BITS-2:0], q_bit};
			rem_q <= rem_next;
		end
		if (cmd.wr_digit) begin
			rem_q    <= '0;
			rd_ptr_q <= cnt_q[radconv_pkg::COUNT_BITS-1] ? '1
				: cnt_q[radconv_pkg::STORE_ADDR_BITS-1:0];
		end
		if (cmd.emit && !status.rd_zero) begin
			rd_ptr_q <= rd_ptr_q - 1'b1;
		end
	end

	// digit store, least significant digit at slot 0
	always_ff @(posedge clk) begin
		if (cmd.wr_digit && !cnt_q[radconv_pkg::COUNT_BITS-1]) begin
			store_mem[cnt_q[radconv_pkg::STORE_ADDR_BITS-1:0]] <= rem_q;
		end
		if (cmd.rd_digit) begin
			rd_data_q <= store_mem[rd_ptr_q];
		end
	end

	assign status.div_last  = (bit_cnt_q == '0);
	assign status.quot_zero = (v_q == '0);
	assign status.rd_zero   = (rd_ptr_q == '0);

	assign digit_value = rd_data_q;
	assign is_negative = neg_q;
	assign last_digit  = status.rd_zero;

endmodule

`default_nettype wire

>>> hdl/radix_converter_top.sv
// radix converter top level: controller plus datapath
// depends on radconv_pkg, radconv_ctrl, radconv_dpath, radix_converter_top_defines.svh
//
// channel   direction  handshake               payload
// config    in         cfg_we                  cfg_index, cfg_data
// chars     in         start && !busy          char_code, last_char
// digits    out        digit_strobe            digit_value, is_negative, last_digit
//
// a character is captured with the multiply, then the add is folded into the accumulator
// the last character then runs the divider for each output digit, one quotient bit per cycle,
// followed by the store write; the stored digits are then read and emitted in turn
// reset clears the controller, accumulator and counters and sets the bases to their defaults;
// the digit store needs no clearing; digits cannot be stalled, each strobe lasts one cycle
`timescale 1ns / 1ps
`default_nettype none

`include "radix_converter_top_defines.svh"

module radix_converter_top #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// configuration writes
	input  wire logic                                   cfg_we,
	input  wire logic [radconv_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [radconv_pkg::BASE_BITS-1:0]      cfg_data,
	// character items
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic [7:0]                             char_code,
	input  wire logic                                   last_char,
	// digit items
	output logic                                        digit_strobe,
	output logic [5:0]                                  digit_value,
	output logic                                        is_negative,
	output logic                                        last_digit
);

	radconv_pkg::radconv_cmd_t    cmd;
	radconv_pkg::radconv_status_t status;

	// sequencing: accumulate, divide, store, then emit most significant first
	radconv_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.last_char    (last_char),
		.status       (status),
		.cmd          (cmd),
		.busy         (busy),
		.digit_strobe (digit_strobe)
	);

	// accumulator, divider and digit store
	radconv_dpath #(
		.VALUE_BITS (VALUE_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.char_code   (char_code),
		.cmd         (cmd),
		.status      (status),
		.digit_value (digit_value),
		.is_negative (is_negative),
		.last_digit  (last_digit)
	);

	// a digit only appears while a numeral is in flight
	`RADCONV_ASSERT_NOW(a_strobe_busy, digit_strobe, busy, "digit strobe while idle")
	// an accepted character always occupies the block next cycle
	`RADCONV_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item not tracked")
	// final digit returns the block to idle
	`RADCONV_ASSERT_NEXT(a_last_idle, digit_strobe && last_digit, !busy, "busy after last digit")
	// digits are spaced by the store read
	`RADCONV_ASSERT_NEXT(a_strobe_gap, digit_strobe, !digit_strobe, "back to back digit strobes")

endmodule

`default_nettype wire
